// File: rtl/apft_pkg.sv
package apft_pkg;

	localparam int WordW    = 32;
	localparam int PassW    = 64;
	localparam int CellStg  = 9;
	localparam int NumCells = 4;
	localparam int NumStg   = CellStg * NumCells;
	localparam int NumRegs  = 6;
	localparam int RegW     = 64;
	localparam int IdxW     = 3;

	localparam logic [WordW-1:0] QNAN_BITS = 32'h7FC0_0000;
	localparam logic [WordW-1:0] INF_BITS  = 32'h7F80_0000;
	localparam logic [WordW-1:0] ONE_BITS  = 32'h3F80_0000;
	localparam logic [WordW-1:0] NEG_ZERO  = 32'h8000_0000;

	// configuration register indexes
	localparam logic [IdxW-1:0] REG_COEF_A = 3'd0;
	localparam logic [IdxW-1:0] REG_COEF_B = 3'd1;
	localparam logic [IdxW-1:0] REG_COEF_C = 3'd2;
	localparam logic [IdxW-1:0] REG_COEF_D = 3'd3;
	localparam logic [IdxW-1:0] REG_COEF_E = 3'd4;
	localparam logic [IdxW-1:0] REG_COEF_F = 3'd5;

	typedef logic [NumStg-1:0]  stg_en_t;
	typedef logic [CellStg-1:0] cell_en_t;

	// index of the highest set bit; 0 for a zero word
	function automatic logic [5:0] msb64(input logic [63:0] v);
		logic [5:0] k;
		k = 6'd0;
		for (int i = 0; i < 64; i++) begin
			if (v[i]) k = 6'(i);
		end
		return k;
	endfunction

endpackage

// File: rtl/apft_cell.sv
module apft_cell import apft_pkg::*; (
	input  logic             clk,
	input  cell_en_t         en,
	input  logic [WordW-1:0] a,
	input  logic [WordW-1:0] b,
	input  logic [WordW-1:0] c,
	input  logic [PassW-1:0] pass_in,
	output logic [WordW-1:0] res,
	output logic [PassW-1:0] pass_out
);

	// stage 1: unpack, specials, 24x24 product
	logic [30:0] aa, ab, ac;
	logic        ps, cs, spec, cz;
	logic [31:0] sval;
	logic [23:0] ma, mb, mc;
	logic signed [11:0] ea, eb, ec;

	always_comb begin
		aa = a[30:0];
		ab = b[30:0];
		ac = c[30:0];
		ps = a[31] ^ b[31];
		cs = c[31];
		cz = (ac == 31'd0);
		spec = 1'b1;
		sval = QNAN_BITS;
		if (aa > INF_BITS[30:0] || ab > INF_BITS[30:0] || ac > INF_BITS[30:0]) begin
			sval = QNAN_BITS;
		end else if (aa == INF_BITS[30:0] || ab == INF_BITS[30:0]) begin
			if (aa == 31'd0 || ab == 31'd0) sval = QNAN_BITS;
			else if (ac == INF_BITS[30:0] && cs != ps) sval = QNAN_BITS;
			else sval = {ps, INF_BITS[30:0]};
		end else if (ac == INF_BITS[30:0]) begin
			sval = c;
		end else if (aa == 31'd0 || ab == 31'd0) begin
			if (cz) sval = (ps == cs) ? {ps, 31'd0} : 32'd0;
			else sval = c;
		end else begin
			spec = 1'b0;
		end
		ma = (a[30:23] == 8'd0) ? {1'b0, a[22:0]} : {1'b1, a[22:0]};
		mb = (b[30:23] == 8'd0) ? {1'b0, b[22:0]} : {1'b1, b[22:0]};
		mc = (c[30:23] == 8'd0) ? {1'b0, c[22:0]} : {1'b1, c[22:0]};
		ea = (a[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, a[30:23]}) - 12'sd150;
		eb = (b[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, b[30:23]}) - 12'sd150;
		ec = (c[30:23] == 8'd0) ? -12'sd149 : $signed({4'd0, c[30:23]}) - 12'sd150;
	end

	logic [47:0]        p_s1;
	logic signed [11:0] ep_s1, eq_s1;
	logic [23:0]        q_s1;
	logic               ps_s1, cs_s1, spec_s1, cz_s1;
	logic [31:0]        sval_s1;
	logic [PassW-1:0]   pass_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			p_s1    <= ma * mb;
			ep_s1   <= ea + eb;
			q_s1    <= mc;
			eq_s1   <= ec;
			ps_s1   <= ps;
			cs_s1   <= cs;
			spec_s1 <= spec;
			cz_s1   <= cz;
			sval_s1 <= sval;
			pass_s1 <= pass_in;
		end
	end

	// stage 2: leading bit positions
	logic [47:0]        p_s2;
	logic [23:0]        q_s2;
	logic [5:0]         kp_s2, kq_s2;
	logic signed [11:0] ep_s2, eq_s2;
	logic               ps_s2, cs_s2, spec_s2, cz_s2;
	logic [31:0]        sval_s2;
	logic [PassW-1:0]   pass_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_s2    <= p_s1;
			q_s2    <= q_s1;
			kp_s2   <= msb64({16'd0, p_s1});
			kq_s2   <= msb64({40'd0, q_s1});
			ep_s2   <= ep_s1;
			eq_s2   <= eq_s1;
			ps_s2   <= ps_s1;
			cs_s2   <= cs_s1;
			spec_s2 <= spec_s1;
			cz_s2   <= cz_s1;
			sval_s2 <= sval_s1;
			pass_s2 <= pass_s1;
		end
	end

	// stage 3: normalize both operands to bit 61
	logic [5:0]  dp, dq;
	logic [63:0] pn, qn;

	always_comb begin
		dp = 6'd61 - kp_s2;
		dq = 6'd61 - kq_s2;
		pn = {16'd0, p_s2} << dp;
		qn = cz_s2 ? 64'd0 : ({40'd0, q_s2} << dq);
	end

	logic [61:0]        pn_s3, qn_s3;
	logic signed [11:0] ep_s3, eq_s3;
	logic               ps_s3, cs_s3, spec_s3, cz_s3;
	logic [31:0]        sval_s3;
	logic [PassW-1:0]   pass_s3;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pn_s3   <= pn[61:0];
			qn_s3   <= qn[61:0];
			ep_s3   <= ep_s2 - $signed({6'd0, dp});
			eq_s3   <= eq_s2 - $signed({6'd0, dq});
			ps_s3   <= ps_s2;
			cs_s3   <= cs_s2;
			spec_s3 <= spec_s2;
			cz_s3   <= cz_s2;
			sval_s3 <= sval_s2;
			pass_s3 <= pass_s2;
		end
	end

	// stage 4: order by magnitude
	logic pbig;
	assign pbig = cz_s3 || (ep_s3 > eq_s3) || (ep_s3 == eq_s3 && pn_s3 >= qn_s3);

	logic [61:0]        big_s4, small_s4;
	logic signed [11:0] ebig_s4, d_s4;
	logic               sbig_s4, esub_s4, spec_s4, cz_s4;
	logic [31:0]        sval_s4;
	logic [PassW-1:0]   pass_s4;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			big_s4   <= pbig ? pn_s3 : qn_s3;
			small_s4 <= pbig ? qn_s3 : pn_s3;
			ebig_s4  <= pbig ? ep_s3 : eq_s3;
			d_s4     <= pbig ? (ep_s3 - eq_s3) : (eq_s3 - ep_s3);
			sbig_s4  <= pbig ? ps_s3 : cs_s3;
			esub_s4  <= ps_s3 != cs_s3;
			spec_s4  <= spec_s3;
			cz_s4    <= cz_s3;
			sval_s4  <= sval_s3;
			pass_s4  <= pass_s3;
		end
	end

	// stage 5: align smaller operand, sticky in bit 0
	logic [63:0] sm_sh, sm_al;
	always_comb begin
		sm_sh = {2'd0, small_s4} >> d_s4[5:0];
		if (cz_s4) sm_al = 64'd0;
		else if (d_s4 >= 12'sd63) sm_al = 64'd1;
		else sm_al = sm_sh | {63'd0, ((sm_sh << d_s4[5:0]) != {2'd0, small_s4})};
	end

	logic [61:0]        big_s5, sm_s5;
	logic signed [11:0] ebig_s5;
	logic               sbig_s5, esub_s5, spec_s5;
	logic [31:0]        sval_s5;
	logic [PassW-1:0]   pass_s5;

	always_ff @(posedge clk) begin
		if (en[4]) begin
			big_s5  <= big_s4;
			sm_s5   <= sm_al[61:0];
			ebig_s5 <= ebig_s4;
			sbig_s5 <= sbig_s4;
			esub_s5 <= esub_s4;
			spec_s5 <= spec_s4;
			sval_s5 <= sval_s4;
			pass_s5 <= pass_s4;
		end
	end

	// stage 6: add or subtract magnitudes
	logic [62:0]        r_s6;
	logic signed [11:0] ebig_s6;
	logic               sbig_s6, spec_s6;
	logic [31:0]        sval_s6;
	logic [PassW-1:0]   pass_s6;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			r_s6    <= esub_s5 ? ({1'b0, big_s5} - {1'b0, sm_s5})
			                   : ({1'b0, big_s5} + {1'b0, sm_s5});
			ebig_s6 <= ebig_s5;
			sbig_s6 <= sbig_s5;
			spec_s6 <= spec_s5;
			sval_s6 <= sval_s5;
			pass_s6 <= pass_s5;
		end
	end

	// stage 7: rounding position
	logic [5:0]         kr;
	logic signed [11:0] be;
	always_comb begin
		kr = msb64({1'b0, r_s6});
		be = $signed({6'd0, kr}) + ebig_s6 + 12'sd127;
	end

	logic [62:0]        r_s7;
	logic signed [11:0] be_s7, sh_s7;
	logic               s_s7, rz_s7, inf_s7, spec_s7;
	logic [31:0]        sval_s7;
	logic [PassW-1:0]   pass_s7;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			r_s7    <= r_s6;
			be_s7   <= be;
			sh_s7   <= (be >= 12'sd1) ? ($signed({6'd0, kr}) - 12'sd23) : (-12'sd149 - ebig_s6);
			s_s7    <= sbig_s6;
			rz_s7   <= (r_s6 == 63'd0);
			inf_s7  <= (be >= 12'sd255);
			spec_s7 <= spec_s6;
			sval_s7 <= sval_s6;
			pass_s7 <= pass_s6;
		end
	end

	// stage 8: shift to 24 bits, round-to-nearest-even decision
	logic [63:0]        rw, mw, rem, half, mask;
	logic signed [11:0] nsh;
	logic               up;
	always_comb begin
		rw   = {1'b0, r_s7};
		nsh  = -sh_s7;
		mask = (64'd1 << sh_s7[5:0]) - 64'd1;
		half = 64'd1 << (sh_s7[5:0] - 6'd1);
		rem  = rw & mask;
		up   = 1'b0;
		if (sh_s7 <= 12'sd0) begin
			mw = rw << nsh[5:0];
		end else if (sh_s7 >= 12'sd64) begin
			mw = 64'd0;
		end else begin
			mw = rw >> sh_s7[5:0];
			up = (rem > half) || (rem == half && mw[0]);
		end
	end

	logic [23:0]      m_s8;
	logic [7:0]       ebits_s8;
	logic             up_s8, s_s8, rz_s8, inf_s8, spec_s8;
	logic [31:0]      sval_s8;
	logic [PassW-1:0] pass_s8;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			m_s8     <= mw[23:0];
			ebits_s8 <= (be_s7 >= 12'sd1) ? be_s7[7:0] - 8'd1 : 8'd0;
			up_s8    <= up;
			s_s8     <= s_s7;
			rz_s8    <= rz_s7;
			inf_s8   <= inf_s7;
			spec_s8  <= spec_s7;
			sval_s8  <= sval_s7;
			pass_s8  <= pass_s7;
		end
	end

	// stage 9: pack
	logic [31:0] bits, rsel;
	always_comb begin
		bits = {1'b0, ebits_s8, 23'd0} + {8'd0, m_s8} + {31'd0, up_s8};
		if (bits >= INF_BITS) bits = INF_BITS;
		if (spec_s8) rsel = sval_s8;
		else if (rz_s8) rsel = 32'd0;
		else if (inf_s8) rsel = {s_s8, INF_BITS[30:0]};
		else rsel = {s_s8, bits[30:0]};
		if (rsel[30:0] > INF_BITS[30:0]) rsel = QNAN_BITS;
	end

	logic [31:0]      res_s9;
	logic [PassW-1:0] pass_s9;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			res_s9  <= rsel;
			pass_s9 <= pass_s8;
		end
	end

	assign res      = res_s9;
	assign pass_out = pass_s9;

endmodule

// File: rtl/apft_lane.sv
module apft_lane import apft_pkg::*; (
	input  logic             clk,
	input  stg_en_t          en,
	input  logic [WordW-1:0] pos_x,
	input  logic [WordW-1:0] pos_y,
	input  logic [WordW-1:0] pos_z,
	input  logic [WordW-1:0] m_x,
	input  logic [WordW-1:0] m_y,
	input  logic [WordW-1:0] m_z,
	input  logic [WordW-1:0] m_t,
	output logic [WordW-1:0] res
);

	logic [WordW-1:0] r0, r1, r2;
	logic [PassW-1:0] pass0, pass1, pass2, pass3;

	apft_cell u_c0 (
		.clk(clk), .en(en[CellStg-1:0]),
		.a(pos_x), .b(m_x), .c(NEG_ZERO),
		.pass_in({pos_z, pos_y}), .res(r0), .pass_out(pass0)
	);

	apft_cell u_c1 (
		.clk(clk), .en(en[2*CellStg-1:CellStg]),
		.a(pass0[31:0]), .b(m_y), .c(r0),
		.pass_in({32'd0, pass0[63:32]}), .res(r1), .pass_out(pass1)
	);

	apft_cell u_c2 (
		.clk(clk), .en(en[3*CellStg-1:2*CellStg]),
		.a(pass1[31:0]), .b(m_z), .c(r1),
		.pass_in(pass1), .res(r2), .pass_out(pass2)
	);

	// translation: p * 1.0 + t
	apft_cell u_c3 (
		.clk(clk), .en(en[4*CellStg-1:3*CellStg]),
		.a(r2), .b(ONE_BITS), .c(m_t),
		.pass_in(pass2), .res(res), .pass_out(pass3)
	);

endmodule

// File: rtl/affine_point_transform_float_top.sv
// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid / in_stall   | pos_x, pos_y, pos_z (binary32)
// output  | out       | out_valid / out_stall | out_x, out_y, out_z (binary32)
// config  | in        | cfg_we                | cfg_idx, cfg_data (64 bits)
//
// One point per clock while out_stall is low; four FMA cells of nine
// stages each, the last stage of the last cell being the output register.
// Reset clears the valid bits and loads the identity matrix.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles are squeezed out and beats keep entering while a result waits.
module affine_point_transform_float_top import apft_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WordW-1:0] pos_x,
	input  logic [WordW-1:0] pos_y,
	input  logic [WordW-1:0] pos_z,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WordW-1:0] out_x,
	output logic [WordW-1:0] out_y,
	output logic [WordW-1:0] out_z,
	input  logic             cfg_we,
	input  logic [IdxW-1:0]  cfg_idx,
	input  logic [RegW-1:0]  cfg_data
);

	// coefficient registers
	logic [RegW-1:0] coef_q [NumRegs];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= {32'd0, ONE_BITS};
			coef_q[1] <= '0;
			coef_q[2] <= {32'd0, ONE_BITS};
			coef_q[3] <= '0;
			coef_q[4] <= {32'd0, ONE_BITS};
			coef_q[5] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_COEF_A: coef_q[0] <= cfg_data;
				REG_COEF_B: coef_q[1] <= cfg_data;
				REG_COEF_C: coef_q[2] <= cfg_data;
				REG_COEF_D: coef_q[3] <= cfg_data;
				REG_COEF_E: coef_q[4] <= cfg_data;
				REG_COEF_F: coef_q[5] <= cfg_data;
				default: ; // out of range: ignored
			endcase
		end
	end

	// stage valid bits and per-stage advance
	stg_en_t vld_q, rdy;

	always_comb begin
		rdy[NumStg-1] = !vld_q[NumStg-1] || !out_stall;
		for (int k = NumStg-2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NumStg; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NumStg-1];

	// lanes: column-major elements, packed two per coefficient register
	apft_lane u_lane_x (
		.clk(clk), .en(rdy), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.m_x(coef_q[0][31:0]), .m_y(coef_q[1][63:32]), .m_z(coef_q[3][31:0]),
		.m_t(coef_q[4][63:32]), .res(out_x)
	);

	apft_lane u_lane_y (
		.clk(clk), .en(rdy), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.m_x(coef_q[0][63:32]), .m_y(coef_q[2][31:0]), .m_z(coef_q[3][63:32]),
		.m_t(coef_q[5][31:0]), .res(out_y)
	);

	apft_lane u_lane_z (
		.clk(clk), .en(rdy), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.m_x(coef_q[1][31:0]), .m_y(coef_q[2][63:32]), .m_z(coef_q[4][31:0]),
		.m_t(coef_q[5][63:32]), .res(out_z)
	);

endmodule
